### hw/rtl/tsk_pkg.sv
// Shared types, token codes and keyword tables for the token scanner.
`timescale 1ns / 1ps
`default_nettype none

package tsk_pkg;

    // Result kinds and error kinds
    localparam logic KIND_TOKEN  = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;
    localparam logic ERR_ILLEGAL = 1'b0;
    localparam logic ERR_COLON   = 1'b1;

    // Token codes
    localparam logic [4:0] CODE_NONE   = 5'd0;
    localparam logic [4:0] CODE_IDENT  = 5'd10;
    localparam logic [4:0] CODE_NUMBER = 5'd11;
    localparam logic [4:0] CODE_EQ     = 5'd12;
    localparam logic [4:0] CODE_NE     = 5'd13;
    localparam logic [4:0] CODE_LE     = 5'd14;
    localparam logic [4:0] CODE_LT     = 5'd15;
    localparam logic [4:0] CODE_GE     = 5'd16;
    localparam logic [4:0] CODE_GT     = 5'd17;
    localparam logic [4:0] CODE_MINUS  = 5'd18;
    localparam logic [4:0] CODE_STAR   = 5'd19;
    localparam logic [4:0] CODE_ASSIGN = 5'd20;
    localparam logic [4:0] CODE_LPAREN = 5'd21;
    localparam logic [4:0] CODE_RPAREN = 5'd22;
    localparam logic [4:0] CODE_SEMI   = 5'd23;
    localparam logic [4:0] CODE_EOF    = 5'd25;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_LPAREN  = 8'd40;
    localparam logic [7:0] CH_RPAREN  = 8'd41;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_DIGIT_0 = 8'd48;
    localparam logic [7:0] CH_DIGIT_9 = 8'd57;
    localparam logic [7:0] CH_COLON   = 8'd58;
    localparam logic [7:0] CH_SEMI    = 8'd59;
    localparam logic [7:0] CH_LESS    = 8'd60;
    localparam logic [7:0] CH_EQUALS  = 8'd61;
    localparam logic [7:0] CH_GREATER = 8'd62;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;

    // Keywords: begin end integer if then else function read write
    localparam int KW_COUNT = 9;
    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd3, 4'd7, 4'd2, 4'd4, 4'd4, 4'd8, 4'd4, 4'd5
    };

    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"b", "e", "g", "i", "n", 8'd0, 8'd0, 8'd0},
        '{"e", "n", "d", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"i", "n", "t", "e", "g", "e", "r", 8'd0},
        '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"t", "h", "e", "n", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"e", "l", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"f", "u", "n", "c", "t", "i", "o", "n"},
        '{"r", "e", "a", "d", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"w", "r", "i", "t", "e", 8'd0, 8'd0, 8'd0}
    };

    // One result as it leaves the scanner
    typedef struct packed {
        logic        kind;
        logic [4:0]  code;
        logic [7:0]  length;
        logic [15:0] line;
        logic        err;
    } tsk_result_t;

    // Up to two results caused by one input beat, in order
    typedef struct packed {
        logic        first_v;
        tsk_result_t first;
        logic        second_v;
        tsk_result_t second;
    } tsk_step_t;

    // Output queue entry
    typedef struct packed {
        tsk_result_t res;
        logic        last;
    } tsk_entry_t;

endpackage

`default_nettype wire

### hw/rtl/tsk_scan.sv
// Scanner state registers and the combinational step logic.
`timescale 1ns / 1ps
`default_nettype none

module tsk_scan
    import tsk_pkg::*;
#(
    parameter int MAX_TOKEN_LEN   = 255,
    parameter int LINE_COUNT_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire logic       req_type,
    input  wire logic [7:0] char_code,
    output tsk_step_t       step
);

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TOKEN_LEN);
    localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDENT,
        ST_NUM,
        ST_LT,
        ST_GT,
        ST_COLON
    } scan_state_t;

    scan_state_t                st_reg,   st_next;
    logic [LW-1:0]              plen_reg, plen_next;
    logic [KW_COUNT-1:0]        cand_reg, cand_next;
    logic [LINE_COUNT_BITS-1:0] line_reg, line_next;

    // Keep keywords whose character at pos equals c
    function automatic logic [KW_COUNT-1:0] kw_match(input logic [LW-1:0] pos,
                                                   input logic [7:0]    c);
        logic [KW_COUNT-1:0] m;
        m = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            m[k] = (32'(pos) < 32'(KW_LEN[k])) && (KW_TEXT[k][pos[2:0]] == c);
        end
        return m;
    endfunction

    logic        is_letter, is_digit, is_ws, is_pending;
    logic [7:0]  len_rpt;
    logic [15:0] line_rpt;
    logic [4:0]  fin_code;
    logic [LW-1:0] plen_inc;
    tsk_result_t fin_res, col_res, eof_res, start_res;
    logic        start_emit;
    scan_state_t start_st;
    logic [LW-1:0] start_plen;
    logic [KW_COUNT-1:0] start_cand;

    always_comb
    begin
        is_letter = ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z)) ||
                    ((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z));
        is_digit  = (char_code >= CH_DIGIT_0) && (char_code <= CH_DIGIT_9);
        is_ws     = (char_code == CH_SPACE) || (char_code == CH_NEWLINE);
        is_pending = (st_reg == ST_IDENT) || (st_reg == ST_NUM) ||
                     (st_reg == ST_LT) || (st_reg == ST_GT);

        len_rpt  = (32'(plen_reg) > 32'd255) ? 8'd255 : 8'(plen_reg);
        line_rpt = (32'(line_reg) > 32'd65535) ? 16'hFFFF : 16'(line_reg);
        plen_inc = (plen_reg < LEN_MAX) ? plen_reg + LW'(1) : plen_reg;

        // Code of the pending token; the lowest matching keyword wins
        unique case (st_reg)
            ST_NUM:  fin_code = CODE_NUMBER;
            ST_LT:   fin_code = CODE_LT;
            ST_GT:   fin_code = CODE_GT;
            default: fin_code = CODE_IDENT;
        endcase
        if (st_reg == ST_IDENT)
        begin
            for (int k = KW_COUNT - 1; k >= 0; k--)
            begin
                if (cand_reg[k] && (32'(plen_reg) == 32'(KW_LEN[k])))
                begin
                    fin_code = 5'(k + 1);
                end
            end
        end

        fin_res = '{kind: KIND_TOKEN, code: fin_code, length: len_rpt,
                    line: line_rpt, err: ERR_ILLEGAL};
        col_res = '{kind: KIND_ERROR, code: CODE_NONE, length: 8'd1,
                    line: line_rpt, err: ERR_COLON};
        eof_res = '{kind: KIND_TOKEN, code: CODE_EOF, length: 8'd0,
                    line: line_rpt, err: ERR_ILLEGAL};

        // Scan the character afresh from idle
        start_emit = 1'b0;
        start_res  = '{kind: KIND_TOKEN, code: CODE_NONE, length: 8'd1,
                       line: line_rpt, err: ERR_ILLEGAL};
        start_st   = ST_IDLE;
        start_plen = '0;
        start_cand = KW_ALL;
        if (is_letter)
        begin
            start_st   = ST_IDENT;
            start_plen = LW'(1);
            start_cand = kw_match('0, char_code);
        end
        else if (is_digit)
        begin
            start_st   = ST_NUM;
            start_plen = LW'(1);
        end
        else
        begin
            unique case (char_code)
                CH_EQUALS:  begin start_emit = 1'b1; start_res.code = CODE_EQ;     end
                CH_MINUS:   begin start_emit = 1'b1; start_res.code = CODE_MINUS;  end
                CH_STAR:    begin start_emit = 1'b1; start_res.code = CODE_STAR;   end
                CH_LPAREN:  begin start_emit = 1'b1; start_res.code = CODE_LPAREN; end
                CH_RPAREN:  begin start_emit = 1'b1; start_res.code = CODE_RPAREN; end
                CH_SEMI:    begin start_emit = 1'b1; start_res.code = CODE_SEMI;   end
                CH_LESS:    begin start_st = ST_LT;    start_plen = LW'(1); end
                CH_GREATER: begin start_st = ST_GT;    start_plen = LW'(1); end
                CH_COLON:   begin start_st = ST_COLON; start_plen = LW'(1); end
                default:
                begin
                    start_emit     = 1'b1;
                    start_res.kind = KIND_ERROR;
                end
            endcase
        end

        step.first_v  = 1'b0;
        step.first    = fin_res;
        step.second_v = 1'b0;
        step.second   = start_res;
        st_next       = st_reg;
        plen_next     = plen_reg;
        cand_next     = cand_reg;
        line_next     = line_reg;

        if (step_en)
        begin
            if (req_type)
            begin
                // End of input: flush, report EOF, back to reset state
                step.first_v  = is_pending || (st_reg == ST_COLON);
                step.first    = (st_reg == ST_COLON) ? col_res : fin_res;
                step.second_v = 1'b1;
                step.second   = eof_res;
                st_next       = ST_IDLE;
                plen_next     = '0;
                cand_next     = KW_ALL;
                line_next     = LINE_COUNT_BITS'(1);
            end
            else if (is_ws)
            begin
                step.first_v = is_pending || (st_reg == ST_COLON);
                step.first   = (st_reg == ST_COLON) ? col_res : fin_res;
                st_next      = ST_IDLE;
                plen_next    = '0;
                cand_next    = KW_ALL;
                if ((char_code == CH_NEWLINE) && (line_reg != LINE_MAX))
                begin
                    line_next = line_reg + LINE_COUNT_BITS'(1);
                end
            end
            else
            begin
                // Default path: close the pending token and rescan
                step.first_v  = 1'b1;
                step.second_v = start_emit;
                st_next       = start_st;
                plen_next     = start_plen;
                cand_next     = start_cand;
                unique case (st_reg) inside
                    ST_IDENT:
                    begin
                        if (is_letter || is_digit)
                        begin
                            step.first_v  = 1'b0;
                            step.second_v = 1'b0;
                            st_next       = st_reg;
                            plen_next     = plen_inc;
                            cand_next     = cand_reg & kw_match(plen_reg, char_code);
                        end
                    end
                    ST_NUM:
                    begin
                        if (is_digit)
                        begin
                            step.first_v  = 1'b0;
                            step.second_v = 1'b0;
                            st_next       = st_reg;
                            plen_next     = plen_inc;
                        end
                    end
                    ST_LT, ST_GT, ST_COLON:
                    begin
                        if (st_reg == ST_COLON)
                        begin
                            step.first = col_res;
                        end
                        if ((char_code == CH_EQUALS) ||
                            ((st_reg == ST_LT) && (char_code == CH_GREATER)))
                        begin
                            step.second_v     = 1'b0;
                            step.first.kind   = KIND_TOKEN;
                            step.first.err    = ERR_ILLEGAL;
                            step.first.length = 8'd2;
                            st_next           = ST_IDLE;
                            plen_next         = '0;
                            cand_next         = KW_ALL;
                            if (st_reg == ST_COLON)
                                step.first.code = CODE_ASSIGN;
                            else if (st_reg == ST_GT)
                                step.first.code = CODE_GE;
                            else if (char_code == CH_EQUALS)
                                step.first.code = CODE_LE;
                            else
                                step.first.code = CODE_NE;
                        end
                    end
                    default:
                    begin
                        step.first_v = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            plen_reg <= '0;
            cand_reg <= KW_ALL;
            line_reg <= LINE_COUNT_BITS'(1);
        end
        else
        begin
            st_reg   <= st_next;
            plen_reg <= plen_next;
            cand_reg <= cand_next;
            line_reg <= line_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/token_scanner_with_keywords.sv
// Top level of the token scanner: input register, scanner and result queue.
//
//  channel   | group         | contents
//  ----------+---------------+-----------------------------------------------
//  input     | s_tvalid/s_tready | s_tdata: char_code; s_tuser: req_type
//  result    | m_tvalid/m_tready | m_tdata: token_code, token_length,
//            |               |   line_number; m_tuser: item_kind, error_kind;
//            |               |   m_tlast: last result of an input beat
//
// Input beats are scanned one per cycle while the result queue has room: a
// beat lands in the input register, is scanned from there and its results land
// in a two-entry result queue. A beat that causes two results holds the scanner
// while the queue drains; the single result port sets that limit.
// Reset clears the scanner to idle with line one and empties both stages.
// A stalled result port holds the queue and, once the input register is
// full, drops s_tready.
`timescale 1ns / 1ps
`default_nettype none

module token_scanner_with_keywords
    import tsk_pkg::*;
#(
    parameter int MAX_TOKEN_LEN   = 255,
    parameter int LINE_COUNT_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [4:0] token_code, [12:5] token_length,
                                        // [28:13] line_number, [31:29] zero
    output logic [1:0]       m_tuser,   // [0] item_kind, [1] error_kind
    output logic             m_tlast
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic       in_type_reg;
    logic [7:0] in_char_reg;

    // Result queue, head in entry 0
    tsk_entry_t q0_reg, q0_next;
    tsk_entry_t q1_reg, q1_next;
    logic [1:0] q_count_reg, q_count_next;

    logic      pop, room, fire;
    tsk_step_t step;

    assign m_tvalid = (q_count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    // Scan only when the queue is empty after this cycle's pop
    assign room     = (q_count_reg == 2'd0) || ((q_count_reg == 2'd1) && m_tready);
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    tsk_scan #(
        .MAX_TOKEN_LEN   (MAX_TOKEN_LEN),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (fire),
        .req_type  (in_type_reg),
        .char_code (in_char_reg),
        .step      (step)
    );

    always_comb
    begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;

        q0_next      = q0_reg;
        q1_next      = q1_reg;
        q_count_next = q_count_reg;
        if (fire)
        begin
            // Load this beat's results; mark the final one as last
            q_count_next = {1'b0, step.first_v} + {1'b0, step.second_v};
            q1_next      = '{res: step.second, last: 1'b1};
            if (step.first_v)
                q0_next = '{res: step.first, last: !step.second_v};
            else
                q0_next = '{res: step.second, last: 1'b1};
        end
        else if (pop)
        begin
            // Advance the queue
            q0_next      = q1_reg;
            q_count_next = q_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            q_count_reg  <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            q_count_reg  <= q_count_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_type_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tdata = {3'b000, q0_reg.res.line, q0_reg.res.length, q0_reg.res.code};
    assign m_tuser = {q0_reg.res.err, q0_reg.res.kind};
    assign m_tlast = q0_reg.last;

endmodule

`default_nettype wire

### bench/lexeme_checker.sv
// Scoreboard for the token scanner: predicts the results of each input beat and checks them.
`timescale 1ns / 1ps

module lexeme_checker
    import tsk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] req_type
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [4:0] code, [12:5] length, [28:13] line, [31:29] zero
    input  wire logic [1:0]  m_tuser,   // [0] item_kind, [1] error_kind
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               outstanding
);

    localparam logic ERR_NONE = 1'b0;

    typedef enum logic [4:0] {
        SC_IDLE    = 5'd0,
        SC_IDENT   = 5'd10,
        SC_NUMBER  = 5'd11,
        SC_LESS    = 5'd15,
        SC_GREATER = 5'd17,
        SC_COLON   = 5'd20
    } scan_t;

    scan_t               scan_st;
    logic [7:0]          tok_len;
    logic [KW_COUNT-1:0] kw_alive;
    logic [15:0]         line_no;
    tsk_entry_t          lexeme_q[$];

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
    endfunction

    function automatic logic holds_token();
        return scan_st == SC_IDENT || scan_st == SC_NUMBER ||
               scan_st == SC_LESS || scan_st == SC_GREATER;
    endfunction

    function automatic void wipe_scan();
        scan_st  = SC_IDLE;
        tok_len  = 8'd0;
        kw_alive = KW_ALL;
    endfunction

    function automatic void push_lexeme(input logic kind, input logic [4:0] code,
                                        input logic [7:0] len, input logic err);
        tsk_entry_t e;
        e.res.kind   = kind;
        e.res.code   = code;
        e.res.length = len;
        e.res.line   = line_no;
        e.res.err    = err;
        e.last       = 1'b0;
        lexeme_q.push_back(e);
    endfunction

    // Drop every keyword that no longer matches at this position; length saturates at 255.
    function automatic void grow_token(input logic [7:0] c);
        if (scan_st == SC_IDENT)
        begin
            for (int k = 0; k < KW_COUNT; k++)
                if (tok_len >= KW_LEN[k] || KW_TEXT[k][tok_len[2:0]] != c)
                    kw_alive[k] = 1'b0;
        end
        if (tok_len != 8'hFF)
            tok_len++;
    endfunction

    function automatic void close_token();
        logic [4:0] code;
        case (scan_st)
            SC_NUMBER:  code = CODE_NUMBER;
            SC_LESS:    code = CODE_LT;
            SC_GREATER: code = CODE_GT;
            default:
            begin
                // keyword codes run from one in table order; scan backwards so the first wins
                code = CODE_IDENT;
                for (int k = KW_COUNT - 1; k >= 0; k--)
                    if (kw_alive[k] && tok_len == 8'(KW_LEN[k]))
                        code = 5'(k + 1);
            end
        endcase
        push_lexeme(KIND_TOKEN, code, tok_len, ERR_NONE);
        wipe_scan();
    endfunction

    function automatic void colon_fault();
        push_lexeme(KIND_ERROR, CODE_NONE, 8'd1, ERR_COLON);
        wipe_scan();
    endfunction

    function automatic void begin_char(input logic [7:0] c);
        wipe_scan();
        if (is_alpha(c))
        begin
            scan_st = SC_IDENT;
            grow_token(c);
        end
        else if (is_numeral(c))
        begin
            scan_st = SC_NUMBER;
            grow_token(c);
        end
        else
        begin
            case (c)
                CH_EQUALS:  push_lexeme(KIND_TOKEN, CODE_EQ, 8'd1, ERR_NONE);
                CH_MINUS:   push_lexeme(KIND_TOKEN, CODE_MINUS, 8'd1, ERR_NONE);
                CH_STAR:    push_lexeme(KIND_TOKEN, CODE_STAR, 8'd1, ERR_NONE);
                CH_LPAREN:  push_lexeme(KIND_TOKEN, CODE_LPAREN, 8'd1, ERR_NONE);
                CH_RPAREN:  push_lexeme(KIND_TOKEN, CODE_RPAREN, 8'd1, ERR_NONE);
                CH_SEMI:    push_lexeme(KIND_TOKEN, CODE_SEMI, 8'd1, ERR_NONE);
                CH_LESS:
                begin
                    scan_st = SC_LESS;
                    tok_len = 8'd1;
                end
                CH_GREATER:
                begin
                    scan_st = SC_GREATER;
                    tok_len = 8'd1;
                end
                CH_COLON:
                begin
                    scan_st = SC_COLON;
                    tok_len = 8'd1;
                end
                default:    push_lexeme(KIND_ERROR, CODE_NONE, 8'd1, ERR_ILLEGAL);
            endcase
        end
    endfunction

    function automatic void pair_or_restart(input logic [4:0] pair_code);
        push_lexeme(KIND_TOKEN, pair_code, 8'd2, ERR_NONE);
        wipe_scan();
    endfunction

    // Predict the results of one accepted input beat and mark the final one.
    function automatic void scan_beat(input logic end_of_input, input logic [7:0] c);
        int         before_n;
        tsk_entry_t tail;
        before_n = lexeme_q.size();
        if (end_of_input)
        begin
            if (scan_st == SC_COLON)
                colon_fault();
            else if (holds_token())
                close_token();
            push_lexeme(KIND_TOKEN, CODE_EOF, 8'd0, ERR_NONE);
            wipe_scan();
            line_no = 16'd1;
        end
        else if (c == CH_SPACE || c == CH_NEWLINE)
        begin
            if (holds_token())
                close_token();
            else if (scan_st == SC_COLON)
                colon_fault();
            else
                wipe_scan();
            if (c == CH_NEWLINE && line_no != 16'hFFFF)
                line_no++;
        end
        else
        begin
            case (scan_st)
                SC_IDENT:
                    if (is_alpha(c) || is_numeral(c))
                        grow_token(c);
                    else
                    begin
                        close_token();
                        begin_char(c);
                    end
                SC_NUMBER:
                    if (is_numeral(c))
                        grow_token(c);
                    else
                    begin
                        close_token();
                        begin_char(c);
                    end
                SC_LESS:
                    if (c == CH_EQUALS)
                        pair_or_restart(CODE_LE);
                    else if (c == CH_GREATER)
                        pair_or_restart(CODE_NE);
                    else
                    begin
                        close_token();
                        begin_char(c);
                    end
                SC_GREATER:
                    if (c == CH_EQUALS)
                        pair_or_restart(CODE_GE);
                    else
                    begin
                        close_token();
                        begin_char(c);
                    end
                SC_COLON:
                    if (c == CH_EQUALS)
                        pair_or_restart(CODE_ASSIGN);
                    else
                    begin
                        colon_fault();
                        begin_char(c);
                    end
                default:
                    begin_char(c);
            endcase
        end
        if (lexeme_q.size() > before_n)
        begin
            tail = lexeme_q.pop_back();
            tail.last = 1'b1;
            lexeme_q.push_back(tail);
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_lexeme(input tsk_entry_t want);
        if (m_tuser[0] !== want.res.kind)
            note_mismatch($sformatf("item_kind %0b, want %0b", m_tuser[0], want.res.kind));
        if (m_tdata[4:0] !== want.res.code)
            note_mismatch($sformatf("token_code %0d, want %0d", m_tdata[4:0], want.res.code));
        if (m_tdata[12:5] !== want.res.length)
            note_mismatch($sformatf("token_length %0d, want %0d", m_tdata[12:5],
                                    want.res.length));
        if (m_tdata[28:13] !== want.res.line)
            note_mismatch($sformatf("line_number %0d, want %0d", m_tdata[28:13],
                                    want.res.line));
        if (m_tuser[1] !== want.res.err)
            note_mismatch($sformatf("error_kind %0b, want %0b", m_tuser[1], want.res.err));
        if (m_tlast !== want.last)
            note_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
        if (m_tdata[31:29] !== 3'b000)
            note_mismatch($sformatf("tdata padding %0b, want zero", m_tdata[31:29]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_scan();
            line_no = 16'd1;
            lexeme_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // retire first: a beat accepted at this edge cannot have a result out yet
            if (m_tvalid && m_tready)
            begin
                if (lexeme_q.size() == 0)
                    note_mismatch("result beat with nothing expected");
                else
                    check_lexeme(lexeme_q.pop_front());
            end
            if (s_tvalid && s_tready)
                scan_beat(s_tuser, s_tdata);
            outstanding <= lexeme_q.size();
        end
    end

endmodule

### bench/testbench.sv
// Top of the token scanner bench: clock, reset, character stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
    import tsk_pkg::*;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Keywords as source text, and the operator spellings fed to the scanner
    localparam string KW_WORDS [KW_COUNT] = '{
        "begin", "end", "integer", "if", "then", "else", "function", "read", "write"
    };
    localparam string OP_WORDS [13] = '{
        "=", "-", "*", "(", ")", ";", "<", "<=", "<>", ">", ">=", ":=", ":"
    };
    // Characters that close a keyword cleanly, or open a new token right after it
    localparam string SEP_CHARS = " \n;(=<:";

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_code
    logic        s_tuser;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [4:0] code, [12:5] length, [28:13] line, [31:29] zero
    logic [1:0]  m_tuser;   // [0] item_kind, [1] error_kind
    logic        m_tlast;

    int   mismatches;
    int   outstanding;
    int   beats_sent = 0;
    int   snd_idle_pct;
    int   rcv_idle_pct;
    logic squeeze_go = 1'b0;
    logic hold_off = 1'b0;

    token_scanner_with_keywords dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lexeme_checker u_lexeme_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // Result side: stall at the current idle rate, or hold off entirely during the squeeze.
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Squeeze: hold the result port for a long stretch while characters keep coming,
    // so the result queue and input register fill and s_tready drops.
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one beat, after a random gap, and hold it until the scanner takes it.
    task automatic send_beat(input logic req, input logic [7:0] ch);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_beat(REQ_CHAR, txt[i]);
    endtask

    // Letter in either case or digit, lower case favoured so keyword prefixes turn up.
    function automatic logic [7:0] ident_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            1:       return 8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
            default: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
        endcase
    endfunction

    // One chunk of source: mostly well-formed tokens with random content, some noise.
    task automatic send_random_chunk();
        string word;
        int    pick;
        word = "";
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            // keyword, sometimes in capitals, cut short or run on into an identifier
            word = KW_WORDS[$urandom_range(0, KW_COUNT - 1)];
            case ($urandom_range(0, 5))
                0:       word = word.toupper();
                1:       word = word.substr(0, word.len() - 2);
                2:       word = $sformatf("%s%c", word, ident_char());
                default: ;
            endcase
            word = $sformatf("%s%c", word, SEP_CHARS[$urandom_range(0, SEP_CHARS.len() - 1)]);
        end
        else if (pick < 36)
        begin
            word = $sformatf("%c", $urandom_range(CH_LOWER_A, CH_LOWER_Z));
            repeat ($urandom_range(0, 8))
                word = $sformatf("%s%c", word, ident_char());
        end
        else if (pick < 48)
        begin
            repeat ($urandom_range(1, 6))
                word = $sformatf("%s%c", word, $urandom_range(CH_DIGIT_0, CH_DIGIT_9));
        end
        else if (pick < 68)
            word = OP_WORDS[$urandom_range(0, 12)];
        else if (pick < 88)
            word = ($urandom_range(0, 3) == 0) ? "\n" : " ";
        else if (pick < 98)
            send_beat(REQ_CHAR, 8'($urandom_range(0, 255)));
        else
            send_beat(REQ_END, 8'($urandom_range(0, 255)));
        send_text(word);
    endtask

    task automatic send_random_run(input int count);
        int stop_at;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at)
            send_random_chunk();
    endtask

    initial
    begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tuser  <= REQ_CHAR;
        m_tready <= 1'b0;
        rst_n    <= 1'b0;
        // sender rarely idles, receiver mostly stalls
        snd_idle_pct = 8;
        rcv_idle_pct <= 88;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keyword, identifier, number, every operator but a lone =, lone < and >,
        // whitespace ending >, colon error, then tab and a high byte as illegal
        // characters, a newline, and a colon left hanging at end of input.
        send_text("if<>9<a>=b<=7> :=()-*;:e");
        send_beat(REQ_CHAR, 8'h09);
        send_beat(REQ_CHAR, 8'hFF);
        send_beat(REQ_CHAR, CH_NEWLINE);
        send_beat(REQ_CHAR, CH_COLON);
        send_beat(REQ_END, 8'h00);

        send_random_run(90);

        // sender mostly idles, receiver rarely stalls; push an over-long identifier
        // that starts like a keyword
        snd_idle_pct = 88;
        rcv_idle_pct <= 8;
        send_random_run(90);
        send_text("begin");
        repeat (252)
            send_beat(REQ_CHAR, ident_char() | 8'h40);
        send_beat(REQ_CHAR, CH_SPACE);

        // no idling on either side, with the squeeze at the start
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        squeeze_go <= 1'b1;
        send_random_run(80);

        // end input and check the line count starts again at one
        send_beat(REQ_END, 8'($urandom_range(0, 255)));
        send_text("begin x\nend");
        send_beat(REQ_END, 8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        // drain: let the count catch up, then wait until nothing is owed
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: the slowest correct run is well under a tenth of this.
    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
hw/rtl/tsk_pkg.sv
hw/rtl/tsk_scan.sv
hw/rtl/token_scanner_with_keywords.sv
bench/lexeme_checker.sv
bench/testbench.sv
